@@ hw/rtl/lzd_pkg.sv @@
// ============================================================================
// lzd_pkg: shared types and constants for the bit-packed LZ77 decoder
// Window geometry, field widths, queue command format and helper functions.
// ============================================================================
package lzd_pkg;

    // Window and field geometry.
    localparam int WINDOW_BITS     = 12;
    localparam int LENGTH_BITS_MAX = 4;
    localparam int LITERAL_BITS    = 8;
    localparam int WINDOW_SIZE     = 1 << WINDOW_BITS;

    // Bits waiting in the accumulator never exceed one full tuple plus seven.
    localparam int ACC_W  = WINDOW_BITS + LENGTH_BITS_MAX + LITERAL_BITS + 7;
    localparam int HELD_W = $clog2(ACC_W + 1);

    // Clamped field widths as used by the front end.
    localparam int DW_W = $clog2(WINDOW_BITS + 1);
    localparam int LW_W = $clog2(LENGTH_BITS_MAX + 1);

    // Configuration register widths and indexes.
    localparam int CFG_DIST_W = 4;
    localparam int CFG_LEN_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_BITS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BITS = 1'd1;
    localparam logic [CFG_DIST_W-1:0] CFG_DIST_RESET = 4'd12;
    localparam logic [CFG_LEN_W-1:0]  CFG_LEN_RESET  = 3'd4;

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Clamped widths handed to the front end.
    typedef struct packed {
        logic [DW_W-1:0] dist_w;
        logic [LW_W-1:0] len_w;
    } t_cfg;

    // One decoded tuple, or an end-of-stream marker with no tuple.
    typedef struct packed {
        logic                       has_tuple;
        logic                       eoi;
        logic [WINDOW_BITS-1:0]     distance;
        logic [LENGTH_BITS_MAX-1:0] len;
        logic [LITERAL_BITS-1:0]    lit;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_LIT
    } t_back_state;

    // Mirror a byte so that its first-read bit (the MSB) lands at bit 0.
    function automatic logic [7:0] reverse8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // A zero width is taken as one, anything above the maximum as the maximum.
    function automatic logic [DW_W-1:0] clamp_dist(input logic [CFG_DIST_W-1:0] v);
        logic [DW_W-1:0] r;
        if (v == '0) begin
            r = DW_W'(1);
        end else if (int'(v) > WINDOW_BITS) begin
            r = DW_W'(WINDOW_BITS);
        end else begin
            r = DW_W'(v);
        end
        return r;
    endfunction

    function automatic logic [LW_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] v);
        logic [LW_W-1:0] r;
        if (v == '0) begin
            r = LW_W'(1);
        end else if (int'(v) > LENGTH_BITS_MAX) begin
            r = LW_W'(LENGTH_BITS_MAX);
        end else begin
            r = LW_W'(v);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lzd_in_if.sv @@
// ============================================================================
// lzd_in_if: compressed byte channel
// Valid/ready channel carrying one compressed byte and its end marker.
// ============================================================================
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ hw/rtl/lzd_out_if.sv @@
// ============================================================================
// lzd_out_if: decoded byte channel
// Valid/ready channel carrying one decoded byte and its status flags.
// ============================================================================
interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       bad_distance;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last,
                    output bad_distance, output stream_done, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input bad_distance, input stream_done, output ready);
endinterface

@@ hw/rtl/lzd_fifo.sv @@
// ============================================================================
// lzd_fifo: command queue
// Short queue of decoded tuples between the bit unpacker and the copy engine.
// ============================================================================
module lzd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output lzd_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    lzd_pkg::t_cmd                     r_mem [lzd_pkg::FIFO_DEPTH];
    logic [lzd_pkg::FIFO_PTR_W-1:0]    r_wptr;
    logic [lzd_pkg::FIFO_PTR_W-1:0]    r_rptr;
    logic [lzd_pkg::FIFO_CNT_W-1:0]    r_count;

    assign o_full  = (r_count == lzd_pkg::FIFO_CNT_W'(lzd_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (int'(r_wptr) == lzd_pkg::FIFO_DEPTH - 1) ?
                          '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (int'(r_rptr) == lzd_pkg::FIFO_DEPTH - 1) ?
                          '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/lzd_front.sv @@
// ============================================================================
// lzd_front: bit unpacker
// Gathers compressed bits into distance, length and literal fields and
// queues one command per finished tuple or per end of stream.
// ============================================================================
module lzd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lzd_pkg::t_cfg i_cfg,
    lzd_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output lzd_pkg::t_cmd o_cmd
);

    localparam int AW = lzd_pkg::ACC_W;
    localparam int HW = lzd_pkg::HELD_W;

    logic [AW-1:0] r_acc;
    logic [HW-1:0] r_held;
    logic [AW-1:0] n_acc;
    logic [HW-1:0] n_held;

    logic          accept;
    logic [AW-1:0] acc_new;
    logic [HW-1:0] held_new;
    logic [HW-1:0] need;
    logic          complete;
    logic [AW-1:0] dist_full;
    logic [AW-1:0] sh1;
    logic [AW-1:0] len_full;
    logic [AW-1:0] sh2;
    logic [AW-1:0] residual;

    // A request is taken whenever the queue has room for a possible command.
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Append the mirrored byte above the bits already held.
    always_comb begin
        acc_new  = r_acc | ({{(AW-8){1'b0}}, lzd_pkg::reverse8(i_in.in_byte)} << r_held);
        held_new = r_held + HW'(8);
        need     = HW'(i_cfg.dist_w) + HW'(i_cfg.len_w) + HW'(lzd_pkg::LITERAL_BITS);
        complete = (held_new >= need);
    end

    // Split the tuple: distance first, then length, then literal.
    always_comb begin
        dist_full = acc_new & ~({AW{1'b1}} << i_cfg.dist_w);
        sh1       = acc_new >> i_cfg.dist_w;
        len_full  = sh1 & ~({AW{1'b1}} << i_cfg.len_w);
        sh2       = sh1 >> i_cfg.len_w;
        residual  = sh2 >> lzd_pkg::LITERAL_BITS;

        o_cmd.has_tuple = complete;
        o_cmd.eoi       = i_in.end_of_input;
        o_cmd.distance  = dist_full[lzd_pkg::WINDOW_BITS-1:0];
        o_cmd.len       = len_full[lzd_pkg::LENGTH_BITS_MAX-1:0];
        o_cmd.lit       = sh2[lzd_pkg::LITERAL_BITS-1:0];

        o_push = accept && (complete || i_in.end_of_input);
    end

    // Next accumulator contents; an end of stream drops any partial tuple.
    always_comb begin
        n_acc  = r_acc;
        n_held = r_held;
        if (accept) begin
            if (i_in.end_of_input) begin
                n_acc  = '0;
                n_held = '0;
            end else if (complete) begin
                n_acc  = residual;
                n_held = held_new - need;
            end else begin
                n_acc  = acc_new;
                n_held = held_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

endmodule

@@ hw/rtl/lzd_back.sv @@
// ============================================================================
// lzd_back: copy engine
// Carries out queued tuples: copies history bytes one per cycle unless the
// output stalls, then emits the literal; all emitted bytes enter the window.
// ============================================================================
module lzd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lzd_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    lzd_out_if.source     o_out
);

    localparam int WB = lzd_pkg::WINDOW_BITS;
    localparam int LB = lzd_pkg::LENGTH_BITS_MAX;

    // History window with registered read.
    logic [7:0] r_win [lzd_pkg::WINDOW_SIZE];
    logic [7:0] r_rd;

    lzd_pkg::t_back_state r_state;
    lzd_pkg::t_back_state n_state;

    logic [WB-1:0] r_wp;
    logic [WB-1:0] n_wp;
    logic [WB:0]   r_bp;
    logic [WB:0]   n_bp;
    logic [7:0]    r_last;
    logic [7:0]    n_last;

    // Current tuple.
    logic [WB-1:0] r_dist;
    logic [WB-1:0] n_dist;
    logic [LB-1:0] r_cnt;
    logic [LB-1:0] n_cnt;
    logic [7:0]    r_lit;
    logic [7:0]    n_lit;
    logic          r_eoi;
    logic          n_eoi;

    // Output register.
    logic          r_ov;
    logic          n_ov;
    logic [7:0]    r_obyte;
    logic [7:0]    n_obyte;
    logic          r_olast;
    logic          n_olast;
    logic          r_obad;
    logic          n_obad;
    logic          r_odone;
    logic          n_odone;

    logic          can_load;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          copy_bad;
    logic [WB-1:0] rd_addr;

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_obyte;
    assign o_out.run_last     = r_olast;
    assign o_out.bad_distance = r_obad;
    assign o_out.stream_done  = r_odone;

    assign can_load = !r_ov || o_out.ready;
    // A source before stream start, or beyond the saturated count, is bad.
    assign copy_bad = ({1'b0, r_dist} > r_bp);

    // Sequencer: next state, tuple bookkeeping and output loading.
    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_bp    = r_bp;
        n_last  = r_last;
        n_dist  = r_dist;
        n_cnt   = r_cnt;
        n_lit   = r_lit;
        n_eoi   = r_eoi;
        n_obyte = r_obyte;
        n_olast = r_olast;
        n_obad  = r_obad;
        n_odone = r_odone;
        o_pop   = 1'b0;
        emit    = 1'b0;
        emit_byte = r_lit;
        rd_addr = r_wp - r_dist;

        unique case (r_state)
            lzd_pkg::S_IDLE: begin
                rd_addr = r_wp - i_cmd.distance;
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_dist = i_cmd.distance;
                    n_cnt  = i_cmd.len;
                    n_lit  = i_cmd.lit;
                    n_eoi  = i_cmd.eoi;
                    if (!i_cmd.has_tuple) begin
                        n_wp = '0;
                        n_bp = '0;
                    end else if (i_cmd.distance != '0 && i_cmd.len != '0) begin
                        n_state = lzd_pkg::S_COPY;
                    end else begin
                        n_state = lzd_pkg::S_LIT;
                    end
                end
            end
            lzd_pkg::S_COPY: begin
                emit = can_load;
                // Distance one reads the byte written last, which the
                // registered read cannot yet return.
                if (copy_bad) begin
                    emit_byte = '0;
                end else if (r_dist == WB'(1)) begin
                    emit_byte = r_last;
                end else begin
                    emit_byte = r_rd;
                end
                // Prefetch the next source byte when this one goes out.
                rd_addr = (emit ? r_wp + 1'b1 : r_wp) - r_dist;
                if (emit) begin
                    n_obyte = emit_byte;
                    n_olast = 1'b0;
                    n_obad  = copy_bad;
                    n_odone = 1'b0;
                    n_last  = emit_byte;
                    n_wp    = r_wp + 1'b1;
                    if (r_bp != (WB+1)'(lzd_pkg::WINDOW_SIZE)) begin
                        n_bp = r_bp + 1'b1;
                    end
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == LB'(1)) begin
                        n_state = lzd_pkg::S_LIT;
                    end
                end
            end
            lzd_pkg::S_LIT: begin
                emit      = can_load;
                emit_byte = r_lit;
                if (emit) begin
                    n_obyte = r_lit;
                    n_olast = 1'b1;
                    n_obad  = 1'b0;
                    n_odone = r_eoi;
                    n_last  = r_lit;
                    n_state = lzd_pkg::S_IDLE;
                    if (r_eoi) begin
                        n_wp = '0;
                        n_bp = '0;
                    end else begin
                        n_wp = r_wp + 1'b1;
                        if (r_bp != (WB+1)'(lzd_pkg::WINDOW_SIZE)) begin
                            n_bp = r_bp + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = lzd_pkg::S_IDLE;
            end
        endcase

        n_ov = emit ? 1'b1 : (o_out.ready ? 1'b0 : r_ov);
    end

    // Window write and registered read.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_win[r_wp] <= emit_byte;
        end
        r_rd <= r_win[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_dist  <= n_dist;
        r_cnt   <= n_cnt;
        r_lit   <= n_lit;
        r_eoi   <= n_eoi;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_obad  <= n_obad;
        r_odone <= n_odone;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzd_pkg::S_IDLE;
            r_wp    <= '0;
            r_bp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_bp    <= n_bp;
            r_ov    <= n_ov;
        end
    end

endmodule

@@ hw/rtl/lz77_bitpacked_decoder.sv @@
// ============================================================================
// lz77_bitpacked_decoder: bit-packed LZ77 stream decoder
// Unpacks distance/length/literal tuples and expands them into bytes.
// ============================================================================
// Usage:
// Compressed bytes enter on i_in, one request per byte; end_of_input marks
// the last byte of a stream. Decoded bytes leave on o_out, one per request,
// with run_last on each tuple's literal, bad_distance on copies from before
// the stream start, and stream_done on the last byte caused by a final input.
// Field widths are set through the write port (index 0 distance width,
// index 1 length width); the user must write them only while the block
// is idle, and the block itself does not enforce this. A byte that
// completes a tuple is queued as a command; the copy engine pops it,
// enters its copy or literal state and then loads the first decoded byte
// into the output register. It fetches each tuple, copies its bytes one
// at a time and then emits the literal. The history window's single port
// pair and the copy loop set this pace; a two-entry command queue lets the
// unpacker keep taking bytes while the copy engine runs.
// Reset clears the bit accumulator, window pointer, byte count and queue;
// the window contents need no clearing. When the receiver stalls, the
// output byte holds, the copy engine waits, and i_in.ready drops once the
// queue is full.
module lz77_bitpacked_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lzd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lzd_in_if.sink                           i_in,
    lzd_out_if.source                        o_out
);

    logic [lzd_pkg::CFG_DIST_W-1:0] r_dist_bits;
    logic [lzd_pkg::CFG_LEN_W-1:0]  r_length_bits;
    lzd_pkg::t_cfg                  cfg;

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    lzd_pkg::t_cmd push_cmd;
    lzd_pkg::t_cmd head_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_bits   <= lzd_pkg::CFG_DIST_RESET;
            r_length_bits <= lzd_pkg::CFG_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lzd_pkg::CFG_DIST_BITS: begin
                    r_dist_bits <= i_cfg_data[lzd_pkg::CFG_DIST_W-1:0];
                end
                lzd_pkg::CFG_LENGTH_BITS: begin
                    r_length_bits <= i_cfg_data[lzd_pkg::CFG_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.dist_w = lzd_pkg::clamp_dist(r_dist_bits);
    assign cfg.len_w  = lzd_pkg::clamp_len(r_length_bits);

    lzd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    lzd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    lzd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // A literal is never flagged as a bad copy.
    a_lit_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.run_last && o_out.bad_distance))
        else $error("literal byte flagged as bad distance");

    // End of stream is only reported on a tuple's literal.
    a_done_on_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_done) |-> o_out.run_last)
        else $error("stream_done on a copied byte");

    // No command is queued while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("command pushed into a full queue");

    // Reset leaves no output pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bit-packed LZ77 stream decoder
// Sends streams of packed distance/length/literal tuples, some well formed
// and some random or cut short. A local decoder model predicts every output
// byte. Outputs are checked in order, with idle bursts on both channels and
// one long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int TARGET_ITEMS = 345;
    localparam int CALM_AFTER   = 295;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int SETTLE       = 24;

    localparam int WB  = lzd_pkg::WINDOW_BITS;
    localparam int LB  = lzd_pkg::LENGTH_BITS_MAX;
    localparam int CDW = lzd_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } t_comp_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
        logic       done;
    } t_dec_byte;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lzd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lzd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lzd_in_if  in_if ();
    lzd_out_if out_if ();

    lz77_bitpacked_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Decoder model state and its copy of the field widths.
    logic [7:0]                     win [0:lzd_pkg::WINDOW_SIZE-1];
    logic [WB-1:0]                  wr_ptr;
    logic [63:0]                    acc;
    int unsigned                    held;
    int unsigned                    produced;
    logic [lzd_pkg::CFG_DIST_W-1:0] dist_cfg;
    logic [lzd_pkg::CFG_LEN_W-1:0]  len_cfg;

    // Compressed bytes still to send and decoded bytes still to arrive.
    t_comp_byte packed_q [$];
    t_dec_byte  decoded_q [$];

    // Stream builder state.
    bit          gen_bits [$];
    int unsigned gen_made;
    int          items_sent;

    // Channel control.
    int  idle_pct;
    bit  calm;
    int  in_gap;
    int  out_gap;
    int  hold_left;
    bit  hold_done;
    bit  in_took;
    int  out_count;
    int  stall_cycles;
    int  err_count;

    // Clock with period 2.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A zero width is taken as one, anything above the maximum as the maximum.
    function automatic int unsigned eff_width(input int unsigned v, input int unsigned maxw);
        if (v == 0) begin
            return 1;
        end
        return (v > maxw) ? maxw : v;
    endfunction

    function automatic t_dec_byte make_byte(input logic [7:0] data, input logic last,
                                            input logic bad);
        t_dec_byte r;
        r.data = data;
        r.last = last;
        r.bad  = bad;
        r.done = 1'b0;
        return r;
    endfunction

    // Every produced byte also enters the history window.
    task automatic keep_byte(input logic [7:0] data);
        win[wr_ptr] = data;
        wr_ptr      = wr_ptr + 1'b1;
        if (produced < lzd_pkg::WINDOW_SIZE) begin
            produced++;
        end
    endtask

    // Model one accepted compressed byte and queue the bytes it decodes to.
    task automatic decode_byte(input logic [7:0] b, input logic eoi);
        t_dec_byte     run [0:16];
        int unsigned   db;
        int unsigned   lb;
        int unsigned   need;
        int            n;
        logic [7:0]    rev;
        logic [WB-1:0] back;
        logic [LB-1:0] len;
        logic [7:0]    lit;
        n    = 0;
        db   = eff_width(dist_cfg, lzd_pkg::WINDOW_BITS);
        lb   = eff_width(len_cfg, lzd_pkg::LENGTH_BITS_MAX);
        need = db + lb + lzd_pkg::LITERAL_BITS;
        for (int i = 0; i < 8; i++) begin
            rev[i] = b[7-i];
        end
        acc  = acc | ({56'd0, rev} << held);
        held = held + 8;

        if (held >= need) begin
            back = WB'(acc & ((64'd1 << db) - 64'd1));
            acc  = acc >> db;
            len  = LB'(acc & ((64'd1 << lb) - 64'd1));
            acc  = acc >> lb;
            lit  = acc[7:0];
            acc  = acc >> lzd_pkg::LITERAL_BITS;
            held = held - need;
            // Copies run one byte at a time, so an overlapping copy repeats itself.
            if (back != 0) begin
                for (int k = 0; k < int'(len); k++) begin
                    if (back > produced) begin
                        run[n] = make_byte(8'h00, 1'b0, 1'b1);
                    end else begin
                        run[n] = make_byte(win[WB'(wr_ptr - back)], 1'b0, 1'b0);
                    end
                    keep_byte(run[n].data);
                    n++;
                end
            end
            run[n] = make_byte(lit, 1'b1, 1'b0);
            keep_byte(lit);
            n++;
        end

        // The final byte drops any partial tuple and restarts the stream.
        if (eoi) begin
            acc      = '0;
            held     = 0;
            wr_ptr   = '0;
            produced = 0;
            if (n > 0) begin
                run[n-1].done = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            decoded_q.push_back(run[i]);
        end
    endtask

    task automatic push_item(input logic [7:0] data, input logic eoi);
        t_comp_byte c;
        c.data = data;
        c.eoi  = eoi;
        packed_q.push_back(c);
        items_sent++;
    endtask

    // Fields are packed with their bit 0 first.
    task automatic put_field(input int unsigned v, input int unsigned w);
        for (int i = 0; i < int'(w); i++) begin
            gen_bits.push_back(bit'((v >> i) & 1));
        end
    endtask

    task automatic add_tuple(input int unsigned back, input int unsigned len,
                             input int unsigned lit);
        put_field(back, eff_width(dist_cfg, lzd_pkg::WINDOW_BITS));
        put_field(len, eff_width(len_cfg, lzd_pkg::LENGTH_BITS_MAX));
        put_field(lit, lzd_pkg::LITERAL_BITS);
        gen_made = gen_made + ((back != 0) ? len : 0) + 1;
        if (gen_made > lzd_pkg::WINDOW_SIZE) begin
            gen_made = lzd_pkg::WINDOW_SIZE;
        end
    endtask

    // Pad to a byte, turn the bits into bytes (first bit at bit 7) and mark
    // the last one; a truncated stream ends at a random earlier byte.
    task automatic end_stream(input bit truncate);
        int         nbytes;
        logic [7:0] b;
        while (gen_bits.size() % 8 != 0) begin
            gen_bits.push_back(bit'($urandom_range(0, 1)));
        end
        nbytes = gen_bits.size() / 8;
        if (truncate && nbytes > 1) begin
            nbytes = $urandom_range(1, nbytes - 1);
        end
        for (int i = 0; i < nbytes; i++) begin
            for (int j = 0; j < 8; j++) begin
                b[7-j] = gen_bits[8*i + j];
            end
            push_item(b, i == nbytes - 1);
        end
        gen_bits.delete();
        gen_made = 0;
    endtask

    // Mostly well-formed streams with random content, some noise, some cut short.
    task automatic random_stream();
        int unsigned db;
        int unsigned lb;
        int unsigned maxd;
        int unsigned back;
        int unsigned sel;
        int          ntup;
        db   = eff_width(dist_cfg, lzd_pkg::WINDOW_BITS);
        lb   = eff_width(len_cfg, lzd_pkg::LENGTH_BITS_MAX);
        maxd = (1 << db) - 1;
        if ($urandom_range(0, 4) == 0) begin
            ntup = $urandom_range(1, 6);
            for (int i = 0; i < ntup; i++) begin
                put_field($urandom_range(0, 255), 8);
            end
            end_stream(1'b0);
        end else begin
            ntup = $urandom_range(1, 8);
            for (int i = 0; i < ntup; i++) begin
                sel = $urandom_range(0, 9);
                if (sel == 1) begin
                    back = (gen_made < maxd) ? $urandom_range(gen_made + 1, maxd)
                                             : $urandom_range(0, maxd);
                end else if (sel == 0 || gen_made == 0) begin
                    back = 0;
                end else begin
                    back = $urandom_range(1, (gen_made < maxd) ? gen_made : maxd);
                end
                add_tuple(back, $urandom_range(0, (1 << lb) - 1), $urandom_range(0, 255));
            end
            // An unfinished tuple at the end of the stream.
            if ($urandom_range(0, 2) == 0) begin
                put_field($urandom,
                          $urandom_range(1, db + lb + lzd_pkg::LITERAL_BITS - 1));
            end
            end_stream($urandom_range(0, 9) == 0);
        end
    endtask

    // Wait until the decoder has drained, then give it time to go idle.
    task automatic settle();
        while (packed_q.size() != 0 || in_if.valid || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [lzd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lzd_pkg::CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        if (idx == lzd_pkg::CFG_DIST_BITS) begin
            dist_cfg = v[lzd_pkg::CFG_DIST_W-1:0];
        end else begin
            len_cfg = v[lzd_pkg::CFG_LEN_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Compressed byte driver: holds each request until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_took) begin
            in_if.valid <= 1'b1;
        end else if (in_gap > 0) begin
            in_gap--;
            in_if.valid <= 1'b0;
        end else if (packed_q.size() == 0) begin
            in_if.valid <= 1'b0;
        end else if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            in_gap = $urandom_range(0, 2);
            in_if.valid <= 1'b0;
        end else begin
            in_if.valid        <= 1'b1;
            in_if.in_byte      <= packed_q[0].data;
            in_if.end_of_input <= packed_q[0].eoi;
            packed_q.pop_front();
        end
    end

    // Output ready: random idle bursts and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!hold_done && out_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            out_if.ready <= 1'b0;
        end else if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            out_gap = $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Accepted compressed bytes feed the model.
    always @(posedge i_clk) begin
        in_took = i_rst_n && in_if.valid && in_if.ready;
        if (in_took) begin
            decode_byte(in_if.in_byte, in_if.end_of_input);
        end
    end

    // Accepted output bytes are checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_dec_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            out_count++;
            if (decoded_q.size() == 0) begin
                $error("unexpected output byte %h", out_if.out_byte);
                err_count++;
            end else begin
                want = decoded_q.pop_front();
                if (out_if.out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, out_if.out_byte);
                    err_count++;
                end
                if (out_if.run_last !== want.last) begin
                    $error("run_last: expected %b, got %b", want.last, out_if.run_last);
                    err_count++;
                end
                if (out_if.bad_distance !== want.bad) begin
                    $error("bad_distance: expected %b, got %b", want.bad,
                           out_if.bad_distance);
                    err_count++;
                end
                if (out_if.stream_done !== want.done) begin
                    $error("stream_done: expected %b, got %b", want.done,
                           out_if.stream_done);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request taken on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Reset, directed streams, then random phases with changing widths.
    initial begin
        int pick_d;
        int pick_l;
        int nstreams;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = lzd_pkg::CFG_DIST_BITS;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.in_byte      = 8'h00;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;
        acc          = '0;
        held         = 0;
        wr_ptr       = '0;
        produced     = 0;
        dist_cfg     = lzd_pkg::CFG_DIST_RESET;
        len_cfg      = lzd_pkg::CFG_LEN_RESET;
        gen_made     = 0;
        items_sent   = 0;
        idle_pct     = 15;
        calm         = 1'b0;
        in_gap       = 0;
        out_gap      = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        in_took      = 1'b0;
        out_count    = 0;
        stall_cycles = 0;
        err_count    = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A lone final byte that completes no tuple.
        push_item(8'hFF, 1'b1);
        // Literal only, zero distance with a length, overlapping copy,
        // a copy from before the start, and one that becomes valid midway.
        add_tuple(0, 0, 8'h00);
        add_tuple(0, 15, 8'hFF);
        add_tuple(1, 15, 8'hA5);
        add_tuple(lzd_pkg::WINDOW_SIZE - 1, 2, 8'h3C);
        add_tuple(22, 3, 8'h81);
        put_field($urandom, 5);
        end_stream(1'b0);

        for (int ph = 0; items_sent < TARGET_ITEMS; ph++) begin
            settle();
            case (ph)
                0: begin pick_d = 0;  pick_l = 0; end
                1: begin pick_d = 15; pick_l = 7; end
                2: begin pick_d = 1;  pick_l = 1; end
                3: begin pick_d = 12; pick_l = 4; end
                4: begin pick_d = 13; pick_l = 5; end
                default: begin
                    pick_d = $urandom_range(0, 15);
                    pick_l = $urandom_range(0, 7);
                end
            endcase
            write_cfg(lzd_pkg::CFG_DIST_BITS, CDW'(pick_d));
            write_cfg(lzd_pkg::CFG_LENGTH_BITS, CDW'(pick_l));
            calm     = (items_sent >= CALM_AFTER);
            idle_pct = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            nstreams = $urandom_range(2, 4);
            for (int s = 0; s < nstreams; s++) begin
                random_stream();
            end
        end

        settle();
        if (decoded_q.size() != 0) begin
            $error("%0d decoded bytes never arrived", decoded_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lzd_pkg.sv
hw/rtl/lzd_in_if.sv
hw/rtl/lzd_out_if.sv
hw/rtl/lzd_fifo.sv
hw/rtl/lzd_front.sv
hw/rtl/lzd_back.sv
hw/rtl/lz77_bitpacked_decoder.sv
sim/tb.sv
